// ----- hw/rtl/mf3_pkg.sv -----
// Shared types and constants of the 3x3 median filter.
`default_nettype none
package mf3_pkg;

  localparam int WIN_SIZE   = 9;
  localparam int COLS_W     = 12;
  localparam int ROWS_W     = 13;
  localparam int ITEMS_W    = 24;
  localparam int CFG_W      = 13;
  localparam int ROW_LIMIT  = 4096;
  localparam int COLS_RESET = 640;
  localparam int ROWS_RESET = 480;
  localparam int OUT_DEPTH  = 8;

  typedef logic [7:0] pix_t;
  typedef pix_t [WIN_SIZE-1:0] win_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  typedef struct packed {
    pix_t median;
    logic frame_end;
  } out_item_t;

  typedef enum logic [0:0] {
    REG_FRAME_COLUMNS = 1'b0,
    REG_FRAME_ROWS    = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mf3_line_store.sv -----
// Line store memory holding the two previous rows, one read and one write port.
`default_nettype none
module mf3_line_store #(
  parameter int DEPTH = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output mf3_pkg::line_pair_t             rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire mf3_pkg::line_pair_t        wr_data
);
  import mf3_pkg::*;

  line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mf3_median.sv -----
// Three-stage pipelined median of a 3x3 window.
`default_nettype none
module mf3_median (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  input  wire mf3_pkg::win_t in_win,
  output logic               out_valid,
  output logic               out_last,
  output mf3_pkg::pix_t      out_median
);
  import mf3_pkg::*;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Rows sorted: lo, mid, hi for each row of the window.
  logic        a_valid, a_last;
  pix_t [2:0]  a_lo, a_mi, a_hi;
  logic        b_valid, b_last;
  pix_t        b_lo, b_mi, b_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
    a_last   <= in_last;
    b_last   <= a_last;
    out_last <= b_last;
    for (int i = 0; i < 3; i++) begin
      a_lo[i] <= min2(min2(in_win[i*3], in_win[i*3+1]), in_win[i*3+2]);
      a_mi[i] <= med3(in_win[i*3], in_win[i*3+1], in_win[i*3+2]);
      a_hi[i] <= max2(max2(in_win[i*3], in_win[i*3+1]), in_win[i*3+2]);
    end
    // The median of nine is the median of the largest low, the middle mid
    // and the smallest high of the sorted rows.
    b_lo       <= max2(max2(a_lo[0], a_lo[1]), a_lo[2]);
    b_mi       <= med3(a_mi[0], a_mi[1], a_mi[2]);
    b_hi       <= min2(min2(a_hi[0], a_hi[1]), a_hi[2]);
    out_median <= med3(b_lo, b_mi, b_hi);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mf3_out_fifo.sv -----
// Result queue that decouples the filter pipeline from the receiver.
`default_nettype none
module mf3_out_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mf3_pkg::out_item_t push_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mf3_pkg::out_item_t      out_item
);
  import mf3_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  out_item_t      store [OUT_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/median_filter_3x3_core.sv -----
// Streaming 3x3 median filter for 8-bit grayscale frames.
//
// Pixels enter on the in channel (in_valid/in_ready, action, pixel) in raster
// order; results leave on the out channel (out_valid/out_ready, median,
// frame_end). Frame size is written on the cfg channel, index 0 for columns
// and index 1 for rows; the user must write it only while the filter is idle,
// which the core does not enforce; cfg_ready is always high. The result for
// a pixel comes with the item columns+1 places later in the stream, so after
// a frame the host sends columns+1 flush items. The last result of a frame
// carries frame_end. Throughput is one item per cycle while in_ready is high.
// A result reaches the out port after its item is accepted in these steps:
// the line store data arrives and the window is updated, the median pipeline
// computes it, and it enters the result queue. Up to eight results are buffered;
// when the receiver stalls, in_ready drops once eight results are owed.
// Reset restores 640 by 480, clears the window and the position counters.
// The line stores are not cleared; rows that are read are always written
// earlier in the same frame.
`default_nettype none
module median_filter_3x3_core #(
  parameter int MAX_COLUMNS = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   action,
  input  wire logic [7:0]             pixel,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  median,
  output logic                        frame_end,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire mf3_pkg::cfg_reg_t      cfg_index,
  input  wire logic [mf3_pkg::CFG_W-1:0] cfg_data
);
  import mf3_pkg::*;

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int THR_W   = ROWS_W + 1 + CNT_W;
  localparam int OCC_W   = $clog2(OUT_DEPTH + 1);
  localparam int COLS_R  = (COLS_RESET < MAX_COLUMNS) ? COLS_RESET : MAX_COLUMNS;
  localparam int THR_R   = (ROWS_RESET + 1) * COLS_R;
  localparam logic [ROWS_W-1:0] ROW_MAX = '1;
  localparam logic [ITEMS_W-1:0] ITEMS_MAX = '1;

  // Configuration, kept in clamped form together with the end-of-frame count.
  logic [CNT_W-1:0]  cols_used;
  logic [ROWS_W-1:0] rows_used;
  logic [THR_W-1:0]  last_thr;
  logic [CNT_W-1:0]  cols_new, mul_cols;
  logic [ROWS_W-1:0] rows_new, mul_rows;
  logic [THR_W-1:0]  thr_new;
  logic              cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    logic [31:0] cw, rw;
    cw = 32'(cfg_data[COLS_W-1:0]);
    rw = 32'(cfg_data[ROWS_W-1:0]);
    if (cw == 32'd0) begin
      cols_new = CNT_W'(1);
    end else if (cw > 32'(MAX_COLUMNS)) begin
      cols_new = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_new = CNT_W'(cw);
    end
    if (rw == 32'd0) begin
      rows_new = ROWS_W'(1);
    end else if (rw > 32'(ROW_LIMIT)) begin
      rows_new = ROWS_W'(ROW_LIMIT);
    end else begin
      rows_new = ROWS_W'(rw);
    end
    mul_cols = (cfg_index == REG_FRAME_COLUMNS) ? cols_new : cols_used;
    mul_rows = (cfg_index == REG_FRAME_ROWS) ? rows_new : rows_used;
    // The last result comes with item rows*cols + cols of the frame.
    thr_new  = THR_W'((THR_W'(mul_rows) + THR_W'(1)) * THR_W'(mul_cols));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_used <= CNT_W'(COLS_R);
      rows_used <= ROWS_W'(ROWS_RESET);
      last_thr  <= THR_W'(THR_R);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_COLUMNS: cols_used <= cols_new;
        REG_FRAME_ROWS:    rows_used <= rows_new;
        default:           ;
      endcase
      last_thr <= thr_new;
    end
  end

  // Position in the padded stream.
  logic [COL_W-1:0]   col_pos, col_next, c0;
  logic [ROWS_W-1:0]  row_pos, row_next, r0;
  logic [ITEMS_W-1:0] items_seen, items_next;
  logic [CNT_W-1:0]   c1;
  logic               accept, emit, last;
  pix_t               v0;

  logic [OCC_W-1:0]   occ;
  logic               pop;

  assign in_ready = (occ < OCC_W'(OUT_DEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    c0 = col_pos;
    r0 = row_pos;
    // A width change while idle can leave the column past the row end.
    if (CNT_W'(col_pos) >= cols_used) begin
      c0 = '0;
      r0 = (row_pos == ROW_MAX) ? row_pos : row_pos + 1'b1;
    end
    v0   = (!action && (r0 < rows_used)) ? pixel : '0;
    emit = (32'(items_seen) >= 32'(cols_used) + 32'd1);
    last = emit && (32'(items_seen) >= 32'(last_thr));
    c1   = CNT_W'(c0) + CNT_W'(1);
    if (last) begin
      col_next   = '0;
      row_next   = '0;
      items_next = '0;
    end else begin
      items_next = (items_seen == ITEMS_MAX) ? items_seen : items_seen + 1'b1;
      if (c1 >= cols_used) begin
        col_next = '0;
        row_next = (r0 == ROW_MAX) ? r0 : r0 + 1'b1;
      end else begin
        col_next = c1[COL_W-1:0];
        row_next = r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      items_seen <= '0;
    end else if (accept) begin
      col_pos    <= col_next;
      row_pos    <= row_next;
      items_seen <= items_next;
    end
  end

  // Stage 1: line store data arrives; window update and write-back.
  logic              s1_valid, s1_first, s1_top_ok, s1_mid_ok, s1_emit, s1_last;
  logic              s1_fwd;
  logic [COL_W-1:0]  s1_addr;
  pix_t              s1_pix;
  line_pair_t        s1_fwd_data, rd_data, line_raw, wr_data;
  pix_t              top, mid;

  assign line_raw = s1_fwd ? s1_fwd_data : rd_data;
  assign top      = s1_top_ok ? line_raw.upper : '0;
  assign mid      = s1_mid_ok ? line_raw.middle : '0;
  assign wr_data  = '{upper: mid, middle: s1_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_addr     <= c0;
      s1_pix      <= v0;
      s1_first    <= (c0 == '0);
      s1_top_ok   <= (r0 >= ROWS_W'(2));
      s1_mid_ok   <= (r0 != '0);
      s1_emit     <= emit;
      s1_last     <= last;
      // The entry being written this cycle is read with its old contents.
      s1_fwd      <= s1_valid && (s1_addr == c0);
      s1_fwd_data <= wr_data;
    end
  end

  mf3_line_store #(
    .DEPTH(MAX_COLUMNS)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c0),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_data)
  );

  win_t win, win_shift, win_zero_shift, win_med, win_next;
  pix_t [2:0] col_in;

  assign col_in = {s1_pix, mid, top};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_shift[i*3]       = win[i*3+1];
      win_shift[i*3+1]     = win[i*3+2];
      win_shift[i*3+2]     = col_in[i];
      win_zero_shift[i*3]   = win[i*3+1];
      win_zero_shift[i*3+1] = win[i*3+2];
      win_zero_shift[i*3+2] = '0;
    end
    // At column zero the result due is the last pixel of the previous row,
    // and the new window holds only the incoming column.
    win_med  = s1_first ? win_zero_shift : win_shift;
    win_next = '0;
    if (!s1_last) begin
      if (s1_first) begin
        for (int i = 0; i < 3; i++) begin
          win_next[i*3+2] = col_in[i];
        end
      end else begin
        win_next = win_shift;
      end
    end
  end

  logic s2_valid, s2_last;
  win_t s2_win;

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_valid) begin
        win <= win_next;
      end
      s2_valid <= s1_valid && s1_emit;
    end
    s2_last <= s1_last;
    s2_win  <= win_med;
  end

  logic      m_valid, m_last;
  pix_t      m_median;
  out_item_t q_item;

  mf3_median u_median (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .in_last    (s2_last),
    .in_win     (s2_win),
    .out_valid  (m_valid),
    .out_last   (m_last),
    .out_median (m_median)
  );

  mf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (m_valid),
    .push_item ('{median: m_median, frame_end: m_last}),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (q_item)
  );

  assign median    = q_item.median;
  assign frame_end = q_item.frame_end;
  assign pop       = out_valid && out_ready;

  // Results owed: accepted items that produce one and are not yet taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(accept && emit) - OCC_W'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- dv/median_filter_3x3_core_test.sv -----
// Self-checking testbench for the streaming 3x3 median filter core.
module median_filter_3x3_core_test;
  import mf3_pkg::*;

  localparam int MAX_COLS = 2048;
  localparam int unsigned ROW_POS_MAX = 8191;
  localparam int unsigned COUNT_MAX = 24'hFFFFFF;
  localparam int SETTLE_CYCLES = 12;
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = ACT_PIXEL;
  logic [7:0] pixel = '0;
  logic out_valid;
  logic out_ready;
  logic [7:0] median;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_FRAME_COLUMNS;
  logic [12:0] cfg_data = '0;

  // Filter state as the testbench sees it.
  logic [11:0] cfg_columns = 12'(COLS_RESET);
  logic [12:0] cfg_rows = 13'(ROWS_RESET);
  pix_t upper_row [MAX_COLS] = '{default: '0};
  pix_t middle_row [MAX_COLS] = '{default: '0};
  pix_t nbhd [WIN_SIZE] = '{default: '0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned pixels_taken = 0;
  logic frame_done = 1'b0;

  out_item_t owed_medians [$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned input_stalls = 0;
  int unsigned send_gap_pct = 13;
  int unsigned recv_gap_pct = 49;
  int unsigned hold_cycles = 0;

  median_filter_3x3_core #(.MAX_COLUMNS(MAX_COLS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .median(median),
    .frame_end(frame_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned used_columns();
    int unsigned c;
    c = 32'(cfg_columns);
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int unsigned used_rows();
    int unsigned r;
    r = 32'(cfg_rows);
    if (r < 1) r = 1;
    if (r > ROW_LIMIT) r = ROW_LIMIT;
    return r;
  endfunction

  // The neighborhood is row-major with the newest column on the right.
  function automatic void shift_column(pix_t top, pix_t mid, pix_t bot);
    pix_t col [3];
    col = '{top, mid, bot};
    for (int i = 0; i < 3; i++) begin
      nbhd[i*3]     = nbhd[i*3 + 1];
      nbhd[i*3 + 1] = nbhd[i*3 + 2];
      nbhd[i*3 + 2] = col[i];
    end
  endfunction

  function automatic pix_t nbhd_median();
    pix_t v [WIN_SIZE];
    pix_t x;
    int j;
    v = nbhd;
    for (int i = 1; i < WIN_SIZE; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    return v[WIN_SIZE/2];
  endfunction

  task automatic predict_median(input logic act, input pix_t px);
    int unsigned ncols, nrows, seen, c, r;
    pix_t v, top, mid, med;
    logic emit, last;
    ncols = used_columns();
    nrows = used_rows();
    seen = pixels_taken;
    c = col_pos;
    r = row_pos;
    if (c >= ncols) begin
      c = 0;
      if (r < ROW_POS_MAX) r++;
    end
    // Pixels that fall below the last row are padding and count as zero.
    v = (act == ACT_PIXEL && r < nrows) ? px : 8'd0;
    top = (r >= 2) ? upper_row[c] : 8'd0;
    mid = (r >= 1) ? middle_row[c] : 8'd0;
    emit = seen >= ncols + 1;
    last = emit && seen >= nrows * ncols + ncols;
    med = '0;
    if (c == 0) begin
      // The result due now belongs to the last pixel of the previous row.
      shift_column('0, '0, '0);
      if (emit) med = nbhd_median();
      nbhd = '{default: '0};
      shift_column(top, mid, v);
    end else begin
      shift_column(top, mid, v);
      if (emit) med = nbhd_median();
    end
    upper_row[c] = mid;
    middle_row[c] = v;
    if (last) begin
      pixels_taken = 0;
      col_pos = 0;
      row_pos = 0;
      nbhd = '{default: '0};
      frame_done = 1'b1;
      frames_closed++;
    end else begin
      pixels_taken = (seen < COUNT_MAX) ? seen + 1 : COUNT_MAX;
      c++;
      if (c >= ncols) begin
        c = 0;
        if (r < ROW_POS_MAX) r++;
      end
      col_pos = c & 'h7FF;
      row_pos = r & 'h1FFF;
    end
    if (emit) owed_medians.push_back(out_item_t'{median: med, frame_end: last});
  endtask

  function automatic pix_t random_pixel();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic act, input pix_t px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    pixel <= px;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_median(act, px);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_geometry(input logic [12:0] cols_word, input logic [12:0] rows_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_COLUMNS;
    cfg_data <= cols_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_columns = cols_word[11:0];
    @(negedge clk);
    cfg_index <= REG_FRAME_ROWS;
    cfg_data <= rows_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_rows = rows_word;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic stream_frame_body(input int unsigned count, input int unsigned hole_pct);
    frame_done = 1'b0;
    repeat (count) begin
      if ($urandom_range(99) < hole_pct) send_item(ACT_FLUSH, pix_t'($urandom_range(255)));
      else send_item(ACT_PIXEL, random_pixel());
    end
  endtask

  // Pads the frame until its last result is due; stray pixels are taken as zero.
  task automatic close_frame(input int unsigned noise_pct);
    while (!frame_done) begin
      if ($urandom_range(99) < noise_pct) send_item(ACT_PIXEL, random_pixel());
      else send_item(ACT_FLUSH, pix_t'($urandom_range(255)));
    end
  endtask

  task automatic test_border_frame();
    write_geometry(13'd3, 13'd3);
    frame_done = 1'b0;
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_PIXEL, 8'd0);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_PIXEL, 8'd0);
    send_item(ACT_PIXEL, 8'd200);
    send_item(ACT_PIXEL, 8'd17);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_FLUSH, 8'd255);
    send_item(ACT_PIXEL, 8'd128);
    send_item(ACT_FLUSH, 8'd0);
    send_item(ACT_PIXEL, 8'd255);
    close_frame(0);
  endtask

  // Zero in both registers gives a one-pixel frame.
  task automatic test_single_pixel_frame();
    wait_idle();
    write_geometry(13'd0, 13'd0);
    frame_done = 1'b0;
    send_item(ACT_PIXEL, 8'd255);
    close_frame(0);
  endtask

  // Narrowing the row wraps the column; shrinking the frame past the current
  // position makes the next result the last one.
  task automatic test_geometry_change();
    wait_idle();
    write_geometry(13'd4, 13'd4);
    stream_frame_body(6, 0);
    wait_idle();
    write_geometry(13'd2, 13'd4);
    stream_frame_body(3, 0);
    wait_idle();
    write_geometry(13'd2, 13'd1);
    close_frame(0);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    write_geometry(13'd8, 13'd8);
    hold_cycles = 300;
    stream_frame_body(64, 0);
    close_frame(0);
  endtask

  // An oversized column word is clamped; the frame is narrowed while idle so
  // that it closes after a short stretch.
  task automatic test_widest_row();
    wait_idle();
    write_geometry(13'h1FFF, 13'd1);
    stream_frame_body(40, 2);
    wait_idle();
    write_geometry(13'd3, 13'd1);
    close_frame(5);
  endtask

  // An oversized row word is clamped; the frame is then cut short while idle.
  task automatic test_tallest_frame();
    wait_idle();
    write_geometry(13'd1, 13'h1FFF);
    stream_frame_body(40, 2);
    wait_idle();
    write_geometry(13'd1, 13'd2);
    close_frame(5);
  endtask

  task automatic test_random_frames(input int unsigned item_goal);
    int unsigned start_count;
    logic [12:0] cols_word, rows_word;
    logic first;
    start_count = items_sent;
    first = 1'b1;
    while (items_sent - start_count < item_goal) begin
      if (first || $urandom_range(1) == 0) begin
        if ($urandom_range(15) == 0) cols_word = 13'($urandom_range(64, 24));
        else cols_word = 13'($urandom_range(10, 1));
        if ($urandom_range(19) == 0) cols_word = '0;
        if ($urandom_range(15) == 0) rows_word = 13'($urandom_range(16, 9));
        else rows_word = 13'($urandom_range(8, 1));
        if ($urandom_range(19) == 0) rows_word = '0;
        wait_idle();
        write_geometry(cols_word, rows_word);
        first = 1'b0;
      end
      stream_frame_body(used_columns() * used_rows(), 3);
      close_frame(10);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && in_valid && !in_ready) input_stalls++;
    if (!rst && out_valid && out_ready) begin
      if (owed_medians.size() == 0) begin
        $error("result with nothing expected: median=%0d frame_end=%0b", median, frame_end);
        mismatches++;
      end else begin
        want = owed_medians.pop_front();
        results_checked++;
        if (median !== want.median) begin
          $error("median: expected %0d, got %0d", want.median, median);
          mismatches++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_border_frame();
    test_single_pixel_frame();
    test_geometry_change();
    test_random_frames(450);

    send_gap_pct = 49;
    recv_gap_pct = 13;
    test_output_backpressure();
    test_random_frames(450);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_widest_row();
    test_tallest_frame();
    test_random_frames(450);

    wait_idle();
    $display("Sent %0d items in %0d frames and checked %0d results; input stalled %0d cycles.",
             items_sent, frames_closed, results_checked, input_stalls);
    $display("Frames ran from a single pixel to clamped oversized settings, idling either side.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Run timed out with %0d results still expected.", owed_medians.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
